@@ hdl/fmct_pkg.sv @@
// shared types and codes for the flow message counter table
// no dependencies
`default_nettype none
package fmct_pkg;

	localparam int FMCT_ENTRIES = 16;
	localparam int IP_W         = 32;
	localparam int PORT_W       = 16;
	localparam int COUNT_W      = 32;
	localparam int CMD_W        = 2;
	localparam int STATUS_W     = 3;

	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	// request token passed from cell to cell
	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [IP_W-1:0]    ip;
		logic [PORT_W-1:0]  port;
		logic               hit;
		logic [COUNT_W-1:0] count;
		logic               free_seen;
	} tok_t;

endpackage
`default_nettype wire

@@ hdl/fmct_cell.sv @@
// one table entry: key, counter and valid bit, plus the token stage after it
// depends on fmct_pkg
`default_nettype none
module fmct_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         tok_vld_in,
	input  wire fmct_pkg::tok_t tok_in,
	input  wire logic         commit,
	output logic              tok_vld_out,
	output fmct_pkg::tok_t    tok_out
);
	import fmct_pkg::*;

	logic               valid_q;
	logic               reserve_q;
	logic [IP_W-1:0]    ip_q;
	logic [PORT_W-1:0]  port_q;
	logic [COUNT_W-1:0] count_q;
	logic               tok_vld_q;
	tok_t               tok_q;

	logic               match;
	logic               claim;
	logic [COUNT_W-1:0] count_inc;
	tok_t               tok_nxt;

	assign match     = valid_q && (ip_q == tok_in.ip) && (port_q == tok_in.port);
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_ONE;
	// lowest free entry along the chain reserves itself for a possible insert
	assign claim     = (tok_in.cmd == CMD_REGISTER) && !valid_q && !tok_in.free_seen;

	always_comb begin
		tok_nxt = tok_in;
		case (tok_in.cmd)
			CMD_REGISTER: begin
				if (match) begin
					tok_nxt.hit   = 1'b1;
					tok_nxt.count = count_inc;
				end
				if (claim) begin
					tok_nxt.free_seen = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (match) begin
					tok_nxt.hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			reserve_q <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_in;
			if (tok_vld_in) begin
				reserve_q <= claim;
				case (tok_in.cmd)
					CMD_REMOVE: begin
						if (match) begin
							valid_q <= 1'b0;
						end
					end
					CMD_CLEAR: begin
						valid_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (commit && reserve_q) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (tok_vld_in && (tok_in.cmd == CMD_REGISTER) && match) begin
			count_q <= count_inc;
		end else if (!tok_vld_in && commit && reserve_q) begin
			ip_q    <= tok_in.ip;
			port_q  <= tok_in.port;
			count_q <= COUNT_ONE;
		end
	end

	assign tok_vld_out = tok_vld_q;
	assign tok_out     = tok_q;

endmodule
`default_nettype wire

@@ hdl/flow_message_counter_table_top.sv @@
// flow message counter table: a command's token walks the cell chain once from start to done,
// and no new command is taken until the token leaves the chain; an insert is written
// at the cycle the result is registered
// the receiver cannot stall: done is a one-cycle strobe
// arst_n clears every valid bit and all control state; no clearing pass is needed
`default_nettype none
module flow_message_counter_table_top #(
	parameter int TABLE_ENTRIES = fmct_pkg::FMCT_ENTRIES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [fmct_pkg::CMD_W-1:0]     cmd,
	input  wire logic [fmct_pkg::IP_W-1:0]      client_ip,
	input  wire logic [fmct_pkg::PORT_W-1:0]    client_port,
	output logic                                done,
	output logic [fmct_pkg::COUNT_W-1:0]        message_count,
	output logic [fmct_pkg::STATUS_W-1:0]       status
);
	import fmct_pkg::*;

	logic               accept;
	logic               busy_q;
	logic               done_q;
	logic [COUNT_W-1:0] count_q;
	logic [STATUS_W-1:0] status_q;
	logic               commit;
	logic               last_vld;
	tok_t               last_tok;
	logic [COUNT_W-1:0] count_nxt;
	logic [STATUS_W-1:0] status_nxt;

	logic tok_vld [0:TABLE_ENTRIES];
	tok_t tok     [0:TABLE_ENTRIES];

	assign accept = start && !busy_q;

	// while no command is accepted the chain head carries the last accepted key for the insert write
	logic [IP_W-1:0]   key_ip_q;
	logic [PORT_W-1:0] key_port_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			key_ip_q   <= client_ip;
			key_port_q <= client_port;
		end
	end

	assign tok_vld[0]        = accept;
	assign tok[0].cmd        = cmd;
	assign tok[0].ip         = accept ? client_ip : key_ip_q;
	assign tok[0].port       = accept ? client_port : key_port_q;
	assign tok[0].hit        = 1'b0;
	assign tok[0].count      = '0;
	assign tok[0].free_seen  = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			fmct_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.tok_vld_in (tok_vld[gi]),
				.tok_in     (tok[gi]),
				.commit     (commit),
				.tok_vld_out(tok_vld[gi+1]),
				.tok_out    (tok[gi+1])
			);
		end
	endgenerate

	assign last_vld = tok_vld[TABLE_ENTRIES];
	assign last_tok = tok[TABLE_ENTRIES];
	assign commit   = last_vld && (last_tok.cmd == CMD_REGISTER) && !last_tok.hit
		&& last_tok.free_seen;

	always_comb begin
		count_nxt  = '0;
		status_nxt = ST_NOTFOUND;
		case (last_tok.cmd)
			CMD_REGISTER: begin
				if (last_tok.hit) begin
					count_nxt  = last_tok.count;
					status_nxt = ST_COUNTED;
				end else if (last_tok.free_seen) begin
					count_nxt  = COUNT_ONE;
					status_nxt = ST_INSERTED;
				end else begin
					status_nxt = ST_FULL;
				end
			end
			CMD_REMOVE: begin
				status_nxt = last_tok.hit ? ST_REMOVED : ST_NOTFOUND;
			end
			CMD_CLEAR: begin
				status_nxt = ST_CLEARED;
			end
			default: begin
				status_nxt = ST_NOTFOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= last_vld;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last_vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last_vld) begin
			count_q  <= count_nxt;
			status_q <= status_nxt;
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign message_count = count_q;
	assign status        = status_q;

	// the block is never busy while a result is being shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accept");

	a_insert_one: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_INSERTED) |-> message_count == COUNT_ONE)
		else $error("insert count not one");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_COUNTED && status != ST_INSERTED) |-> message_count == '0)
		else $error("nonzero count on non-register result");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		last_vld |-> busy_q && !tok_vld[0])
		else $error("token out of chain while idle or overlapping");

endmodule
`default_nettype wire

@@ sim/flow_message_counter_table_top_test.sv @@
// self-checking testbench for flow_message_counter_table_top: a flow table scoreboard
// predicts each result, plain tasks drive directed and random command streams
// depends on fmct_pkg and the top level in hdl
`timescale 1ns / 100ps
module flow_message_counter_table_top_test;
	import fmct_pkg::*;

	// cmd value three has no meaning, the block answers not found
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int POOL_MAX = 48;

	typedef struct {
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
	} flow_result_t;

	typedef struct {
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
	} flow_key_t;

	class flow_table_scoreboard;
		bit                 valid     [FMCT_ENTRIES];
		logic [IP_W-1:0]    ip_tab    [FMCT_ENTRIES];
		logic [PORT_W-1:0]  port_tab  [FMCT_ENTRIES];
		logic [COUNT_W-1:0] count_tab [FMCT_ENTRIES];
		flow_result_t       awaited   [$];
		int                 errors;

		function new();
			errors = 0;
			foreach (valid[i]) valid[i] = 1'b0;
		endfunction

		function int lookup(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
			for (int i = 0; i < FMCT_ENTRIES; i++)
				if (valid[i] && ip_tab[i] == ip && port_tab[i] == port) return i;
			return -1;
		endfunction

		function int first_free();
			for (int i = 0; i < FMCT_ENTRIES; i++)
				if (!valid[i]) return i;
			return -1;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
				logic [PORT_W-1:0] port);
			flow_result_t r;
			int idx;
			r.count  = '0;
			r.status = ST_NOTFOUND;
			case (cmd)
				CMD_REGISTER: begin
					idx = lookup(ip, port);
					if (idx >= 0) begin
						// counter sticks at its maximum
						if (count_tab[idx] != COUNT_MAX)
							count_tab[idx] = count_tab[idx] + COUNT_ONE;
						r.count  = count_tab[idx];
						r.status = ST_COUNTED;
					end else begin
						idx = first_free();
						if (idx >= 0) begin
							valid[idx]     = 1'b1;
							ip_tab[idx]    = ip;
							port_tab[idx]  = port;
							count_tab[idx] = COUNT_ONE;
							r.count        = COUNT_ONE;
							r.status       = ST_INSERTED;
						end else begin
							r.status = ST_FULL;
						end
					end
				end
				CMD_REMOVE: begin
					idx = lookup(ip, port);
					if (idx >= 0) begin
						valid[idx] = 1'b0;
						r.status   = ST_REMOVED;
					end
				end
				CMD_CLEAR: begin
					foreach (valid[i]) valid[i] = 1'b0;
					r.status = ST_CLEARED;
				end
				default: ;
			endcase
			awaited.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [COUNT_W-1:0] count, logic [STATUS_W-1:0] status);
			flow_result_t r;
			if (awaited.size() == 0) begin
				report("result beat with nothing outstanding");
				return;
			end
			r = awaited.pop_front();
			if (count !== r.count)
				report($sformatf("message_count %h, predicted %h", count, r.count));
			if (status !== r.status)
				report($sformatf("status %0d, predicted %0d", status, r.status));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    cmd;
	logic [IP_W-1:0]     client_ip;
	logic [PORT_W-1:0]   client_port;
	logic                done;
	logic [COUNT_W-1:0]  message_count;
	logic [STATUS_W-1:0] status;

	flow_table_scoreboard sb = new();
	flow_key_t            pool [POOL_MAX];
	int                   burst_left;

	flow_message_counter_table_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.client_ip    (client_ip),
		.client_port  (client_port),
		.done         (done),
		.message_count(message_count),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result first, so a result and the next command at one edge stay in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) sb.check_result(message_count, status);
			else if (done !== 1'b0) sb.report("done strobe unknown");
			if (start === 1'b1 && busy === 1'b0) sb.note_command(cmd, client_ip, client_port);
		end
	end

	initial begin
		#5ms;
		$display("flow_message_counter_table_top_test: errors");
		$finish;
	end

	task send_beat(logic [CMD_W-1:0] c, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
		@(negedge clk);
		start       = 1'b1;
		cmd         = c;
		client_ip   = ip;
		client_port = port;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// junk on the fields while start is low
	task idle_for(int n);
		repeat (n) begin
			@(negedge clk);
			start       = 1'b0;
			cmd         = CMD_W'($urandom_range(0, 3));
			client_ip   = $urandom;
			client_port = PORT_W'($urandom_range(0, 65535));
		end
	endtask

	task issue(logic [CMD_W-1:0] c, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
		send_beat(c, ip, port);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 9) < 7) idle_for($urandom_range(1, 25));
		end
	endtask

	task drain();
		idle_for(1);
		while (sb.awaited.size() != 0) @(negedge clk);
	endtask

	task build_pool(int n);
		for (int i = 0; i < n; i++) begin
			pool[i].ip   = $urandom;
			pool[i].port = PORT_W'($urandom_range(0, 65535));
			// neighbors that share half of the key or differ in one bit
			if (i > 0 && i % 5 == 1) pool[i].ip = pool[i-1].ip;
			if (i > 0 && i % 5 == 2) pool[i].port = pool[i-1].port;
			if (i > 0 && i % 5 == 3) begin
				pool[i].port = pool[i-1].port;
				pool[i].ip   = pool[i-1].ip ^ (32'd1 << $urandom_range(0, 31));
			end
		end
	endtask

	task random_phase(int n_items, int pool_size, int clear_pct);
		int pick;
		int idx;
		build_pool(pool_size);
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			// a few hot keys climb to higher counts
			idx = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, pool_size - 1);
			if (pick < clear_pct)
				issue(CMD_CLEAR, $urandom, PORT_W'($urandom_range(0, 65535)));
			else if (pick < 70)
				issue(CMD_REGISTER, pool[idx].ip, pool[idx].port);
			else if (pick < 88)
				issue(CMD_REMOVE, pool[idx].ip, pool[idx].port);
			else if (pick < 93)
				issue(CMD_REGISTER, $urandom, PORT_W'($urandom_range(0, 65535)));
			else if (pick < 97)
				issue(CMD_REMOVE, $urandom, PORT_W'($urandom_range(0, 65535)));
			else
				issue(CMD_SPARE, pool[idx].ip, pool[idx].port);
		end
		drain();
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = CMD_REGISTER;
		client_ip   = '0;
		client_port = '0;
		burst_left  = $urandom_range(1, 24);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// key extremes, hit and miss on each command, spare command
		issue(CMD_REGISTER, '0, '0);
		issue(CMD_REGISTER, '0, '0);
		issue(CMD_REGISTER, '1, '1);
		issue(CMD_REGISTER, '1, '0);
		issue(CMD_REGISTER, '0, '1);
		issue(CMD_REMOVE, '0, '0);
		issue(CMD_REMOVE, '0, '0);
		issue(CMD_SPARE, '1, '1);
		issue(CMD_REGISTER, '1, '1);
		// fill up, then a new key finds the table full
		for (int i = 0; i < FMCT_ENTRIES - 3; i++)
			issue(CMD_REGISTER, IP_W'(32'h0A00_0000 + i), PORT_W'(16'h1000 + i));
		issue(CMD_REGISTER, '0, '0);
		issue(CMD_REMOVE, '1, '0);
		issue(CMD_REGISTER, '0, '0);
		issue(CMD_CLEAR, '0, '0);
		issue(CMD_REGISTER, '1, '0);
		drain();

		// the counter maximum of 2^32 - 1 is out of reach in simulation
		random_phase(300, 6, 2);
		random_phase(300, 20, 1);
		random_phase(300, 40, 1);
		random_phase(250, 16, 1);
		random_phase(274, 48, 1);

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("flow_message_counter_table_top_test: clean");
		end else begin
			if (sb.awaited.size() != 0)
				$display("%0d results never arrived", sb.awaited.size());
			$display("flow_message_counter_table_top_test: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/fmct_pkg.sv
hdl/fmct_cell.sv
hdl/flow_message_counter_table_top.sv
sim/flow_message_counter_table_top_test.sv
